/* src/timed_event_scheduler_defines.svh */
// assertion macros shared by the scheduler rtl
// depends on nothing; included by modules that carry assertions
`ifndef TIMED_EVENT_SCHEDULER_DEFINES_SVH
`define TIMED_EVENT_SCHEDULER_DEFINES_SVH

// condition in this cycle implies a condition in the same cycle
`define TES_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("scheduler assertion failed");

// condition in this cycle implies a condition in the next cycle
`define TES_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("scheduler assertion failed");

`endif

/* src/tes_pkg.sv */
// shared types, constants and codes of the timed event scheduler
// depends on nothing
package tes_pkg;

    localparam int HEAP_DEPTH  = 256;
    localparam int HEAP_AW     = $clog2(HEAP_DEPTH);
    localparam int CHORE_DEPTH = 64;
    localparam int CHORE_AW    = $clog2(CHORE_DEPTH);
    localparam int TAG_BITS    = 16;
    localparam int TIME_BITS   = 63;
    localparam int ID_BITS     = 32;
    localparam int DELAY_BITS  = 32;

    localparam logic [ID_BITS-1:0]   ID_STOP  = '1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef enum logic [1:0] {
        OP_POST = 2'd0,
        OP_POP  = 2'd1,
        OP_STOP = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_POSTED = 3'd0,
        ST_CHORE  = 3'd1,
        ST_TIMED  = 3'd2,
        ST_STOP   = 3'd3,
        ST_EMPTY  = 3'd4,
        ST_FULL   = 3'd5
    } t_status;

    // field order gives the pop order when compared as one unsigned word
    typedef struct packed {
        logic [TIME_BITS-1:0] expiry;
        logic [ID_BITS-1:0]   ident;
        logic                 stop;
        logic [TAG_BITS-1:0]  handle;
    } t_heap_ent;

    typedef struct packed {
        logic [ID_BITS-1:0]  ident;
        logic [TAG_BITS-1:0] handle;
    } t_chore_ent;

    typedef struct packed {
        logic [2:0]           status;
        logic [ID_BITS-1:0]   event_id;
        logic [TAG_BITS-1:0]  event_tag;
        logic [TIME_BITS-1:0] current_time;
    } t_result;

    // controller to datapath commands
    typedef struct packed {
        logic latch_in;
        logic post_chore;
        logic ins_begin;
        logic res_full;
        logic res_empty;
        logic chore_rd;
        logic chore_take;
        logic top_rd;
        logic top_take;
        logic up_place;
        logic up_rd;
        logic up_cmp;
        logic dn_rd;
        logic dn_cmp;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        t_op  op;
        logic delay_zero;
        logic chore_full;
        logic chore_empty;
        logic heap_full;
        logic heap_empty;
        logic heap_one;
        logic k_zero;
        logic up_done;
        logic dn_done;
    } t_dp_stat;

endpackage

/* src/tes_if.sv */
// handshake channels of the scheduler: request and result
// depends on tes_pkg
interface tes_req_if;
    import tes_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            operation;
    logic [DELAY_BITS-1:0] delay_ns;
    logic [TAG_BITS-1:0]   tag;
    modport source (output valid, operation, delay_ns, tag, input ready);
    modport sink   (input valid, operation, delay_ns, tag, output ready);
endinterface

interface tes_res_if;
    import tes_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [2:0]           status;
    logic [ID_BITS-1:0]   event_id;
    logic [TAG_BITS-1:0]  event_tag;
    logic [TIME_BITS-1:0] current_time;
    modport source (output valid, status, event_id, event_tag, current_time, input ready);
    modport sink   (input valid, status, event_id, event_tag, current_time, output ready);
endinterface

/* src/tes_ctrl.sv */
// scheduler controller: sequences one request through fifo and heap steps
// depends on tes_pkg and timed_event_scheduler_defines.svh
`include "timed_event_scheduler_defines.svh"

module tes_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tes_pkg::t_dp_stat i_stat,
    output tes_pkg::t_dp_cmd  o_cmd
);
    import tes_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CHORE_RD,
        S_CHORE_TAKE,
        S_TOP_RD,
        S_TOP_TAKE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_in_fire;
    logic   w_slot_free;

    assign w_in_fire   = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_POST: begin
                        if (i_stat.delay_zero) begin
                            if (i_stat.chore_full) o_cmd.res_full = 1'b1;
                            else                   o_cmd.post_chore = 1'b1;
                            n_state = S_FINISH;
                        end else if (i_stat.heap_full) begin
                            o_cmd.res_full = 1'b1;
                            n_state        = S_FINISH;
                        end else begin
                            o_cmd.ins_begin = 1'b1;
                            n_state         = S_UP_RD;
                        end
                    end
                    OP_STOP: begin
                        if (i_stat.heap_full) begin
                            o_cmd.res_full = 1'b1;
                            n_state        = S_FINISH;
                        end else begin
                            o_cmd.ins_begin = 1'b1;
                            n_state         = S_UP_RD;
                        end
                    end
                    OP_POP: begin
                        if (!i_stat.chore_empty)     n_state = S_CHORE_RD;
                        else if (!i_stat.heap_empty) n_state = S_TOP_RD;
                        else begin
                            o_cmd.res_empty = 1'b1;
                            n_state         = S_FINISH;
                        end
                    end
                    default: begin
                        o_cmd.res_empty = 1'b1;
                        n_state         = S_FINISH;
                    end
                endcase
            end
            S_CHORE_RD: begin
                o_cmd.chore_rd = 1'b1;
                n_state        = S_CHORE_TAKE;
            end
            S_CHORE_TAKE: begin
                o_cmd.chore_take = 1'b1;
                n_state          = S_FINISH;
            end
            S_TOP_RD: begin
                o_cmd.top_rd = 1'b1;
                n_state      = S_TOP_TAKE;
            end
            S_TOP_TAKE: begin
                o_cmd.top_take = 1'b1;
                n_state        = i_stat.heap_one ? S_FINISH : S_DN_RD;
            end
            S_UP_RD: begin
                if (i_stat.k_zero) begin
                    o_cmd.up_place = 1'b1;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.up_rd = 1'b1;
                    n_state     = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_cmd.up_cmp = 1'b1;
                n_state      = i_stat.up_done ? S_FINISH : S_UP_RD;
            end
            S_DN_RD: begin
                o_cmd.dn_rd = 1'b1;
                n_state     = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.dn_cmp = 1'b1;
                n_state      = i_stat.dn_done ? S_FINISH : S_DN_RD;
            end
            S_FINISH: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output valid: set on load, cleared on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load)   n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `TES_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_in_fire, r_state == S_DISPATCH)
    `TES_ASSERT_NEXT(a_finish_waits_slot, i_clk, i_rst_n, (r_state == S_FINISH) && !w_slot_free, (r_state == S_FINISH) && r_out_valid)
    `TES_ASSERT_SAME(a_one_step_cmd, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.up_cmp, o_cmd.dn_cmp, o_cmd.top_take, o_cmd.chore_take, o_cmd.out_load}))

endmodule

/* src/tes_dp.sv */
// scheduler datapath: time, id counter, chore fifo memory, heap memory
// depends on tes_pkg
module tes_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tes_pkg::TIME_BITS-1:0]  i_cfg_wdata,
    input  logic [1:0]                     i_operation,
    input  logic [tes_pkg::DELAY_BITS-1:0] i_delay_ns,
    input  logic [tes_pkg::TAG_BITS-1:0]   i_tag,
    input  tes_pkg::t_dp_cmd               i_cmd,
    output tes_pkg::t_dp_stat              o_stat,
    output tes_pkg::t_result               o_result
);
    import tes_pkg::*;

    // latched request
    t_op                   r_op;
    logic [DELAY_BITS-1:0] r_delay;
    logic [TAG_BITS-1:0]   r_tag;

    // scheduler state
    logic [TIME_BITS-1:0] r_now;
    logic [ID_BITS-1:0]   r_id_cnt;
    logic [HEAP_AW:0]     r_heap_cnt;
    logic [CHORE_AW-1:0]  r_chore_head;
    logic [CHORE_AW:0]    r_chore_cnt;

    // heap walk
    t_heap_ent          r_new;
    logic [HEAP_AW-1:0] r_k;

    // result being built and result on the port
    t_result r_res;
    t_result r_out;

    // memories
    t_heap_ent  heap_mem [HEAP_DEPTH];
    t_chore_ent chore_mem [CHORE_DEPTH];
    t_heap_ent  r_rd_a, r_rd_b;
    t_chore_ent r_chore_rd;

    logic [TIME_BITS:0]   w_sum;
    logic [TIME_BITS-1:0] w_expiry;
    logic [ID_BITS-1:0]   w_nid;
    logic [HEAP_AW-1:0]   w_parent;
    logic [HEAP_AW:0]     w_left, w_right;
    logic                 w_left_ok, w_right_ok, w_right_less;
    t_heap_ent            w_child;
    logic [HEAP_AW-1:0]   w_child_idx;
    logic                 w_child_ok, w_dn_move, w_up_move;
    logic [HEAP_AW-1:0]   w_rd_a_addr, w_rd_b_addr;
    logic                 w_wr_en;
    logic [HEAP_AW-1:0]   w_wr_addr;
    t_heap_ent            w_wr_data;
    logic [CHORE_AW-1:0]  w_chore_tail;

    // saturating expiry and next id
    assign w_sum    = {1'b0, r_now} + {{(TIME_BITS + 1 - DELAY_BITS){1'b0}}, r_delay};
    assign w_expiry = w_sum[TIME_BITS] ? TIME_MAX : w_sum[TIME_BITS-1:0];
    assign w_nid    = r_id_cnt + ID_BITS'(2);

    // heap tree indexes
    assign w_parent = HEAP_AW'((r_k - HEAP_AW'(1)) >> 1);
    assign w_left   = {r_k, 1'b1};
    assign w_right  = {r_k, 1'b0} + (HEAP_AW + 1)'(2);

    // sift down choice: smaller valid child, moved up while below the hole item
    assign w_left_ok    = w_left < r_heap_cnt;
    assign w_right_ok   = w_right < r_heap_cnt;
    assign w_right_less = w_right_ok && (r_rd_b < r_rd_a);
    assign w_child      = w_right_less ? r_rd_b : r_rd_a;
    assign w_child_idx  = w_right_less ? w_right[HEAP_AW-1:0] : w_left[HEAP_AW-1:0];
    assign w_child_ok   = w_left_ok;
    assign w_dn_move    = w_child_ok && (w_child < r_new);
    assign w_up_move    = r_new < r_rd_a;

    // heap read addresses
    always_comb begin
        w_rd_a_addr = '0;
        w_rd_b_addr = '0;
        if (i_cmd.top_rd) begin
            w_rd_b_addr = HEAP_AW'(r_heap_cnt - (HEAP_AW + 1)'(1));
        end else if (i_cmd.up_rd) begin
            w_rd_a_addr = w_parent;
        end else if (i_cmd.dn_rd) begin
            w_rd_a_addr = w_left[HEAP_AW-1:0];
            w_rd_b_addr = w_right[HEAP_AW-1:0];
        end
    end

    // heap write port
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_k;
        w_wr_data = r_new;
        if (i_cmd.up_place) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.up_cmp) begin
            w_wr_en = 1'b1;
            if (w_up_move) w_wr_data = r_rd_a;
        end else if (i_cmd.dn_cmp) begin
            w_wr_en = 1'b1;
            if (w_dn_move) w_wr_data = w_child;
        end
    end

    // heap memory, two registered reads
    always_ff @(posedge i_clk) begin
        if (w_wr_en) heap_mem[w_wr_addr] <= w_wr_data;
        r_rd_a <= heap_mem[w_rd_a_addr];
        r_rd_b <= heap_mem[w_rd_b_addr];
    end

    // chore fifo memory
    assign w_chore_tail = r_chore_head + r_chore_cnt[CHORE_AW-1:0];
    always_ff @(posedge i_clk) begin
        if (i_cmd.post_chore) chore_mem[w_chore_tail] <= '{ident: w_nid, handle: r_tag};
        r_chore_rd <= chore_mem[r_chore_head];
    end

    // request latch, walk registers and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op    <= t_op'(i_operation);
            r_delay <= i_delay_ns;
            r_tag   <= i_tag;
        end
        if (i_cmd.ins_begin) begin
            r_k                <= r_heap_cnt[HEAP_AW-1:0];
            r_new.expiry       <= w_expiry;
            r_res.status       <= ST_POSTED;
            r_res.current_time <= r_now;
            if (r_op == OP_STOP) begin
                r_new.ident     <= ID_STOP;
                r_new.stop      <= 1'b1;
                r_new.handle    <= '0;
                r_res.event_id  <= ID_STOP;
                r_res.event_tag <= '0;
            end else begin
                r_new.ident     <= w_nid + ID_BITS'(1);
                r_new.stop      <= 1'b0;
                r_new.handle    <= r_tag;
                r_res.event_id  <= w_nid + ID_BITS'(1);
                r_res.event_tag <= r_tag;
            end
        end
        if (i_cmd.post_chore) begin
            r_res <= '{status: ST_POSTED, event_id: w_nid, event_tag: r_tag,
                       current_time: r_now};
        end
        if (i_cmd.res_full) begin
            r_res <= '{status: ST_FULL, event_id: '0, event_tag: '0, current_time: r_now};
        end
        if (i_cmd.res_empty) begin
            r_res <= '{status: ST_EMPTY, event_id: '0, event_tag: '0, current_time: r_now};
        end
        if (i_cmd.chore_take) begin
            r_res <= '{status: ST_CHORE, event_id: r_chore_rd.ident,
                       event_tag: r_chore_rd.handle, current_time: r_now};
        end
        if (i_cmd.top_take) begin
            r_res <= '{status: (r_rd_a.stop ? ST_STOP : ST_TIMED), event_id: r_rd_a.ident,
                       event_tag: r_rd_a.handle, current_time: r_rd_a.expiry};
            r_new <= r_rd_b;
            r_k   <= '0;
        end
        if (i_cmd.up_cmp && w_up_move) r_k <= w_parent;
        if (i_cmd.dn_cmp && w_dn_move) r_k <= w_child_idx;
        if (i_cmd.out_load) r_out <= r_res;
    end

    // control state of the stores and time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now        <= '0;
            r_id_cnt     <= '0;
            r_heap_cnt   <= '0;
            r_chore_head <= '0;
            r_chore_cnt  <= '0;
        end else begin
            if (i_cfg_we) r_now <= i_cfg_wdata;
            if (i_cmd.top_take) r_now <= r_rd_a.expiry;
            if (i_cmd.post_chore || (i_cmd.ins_begin && r_op == OP_POST)) r_id_cnt <= w_nid;
            if (i_cmd.ins_begin) r_heap_cnt <= r_heap_cnt + (HEAP_AW + 1)'(1);
            if (i_cmd.top_take) r_heap_cnt <= r_heap_cnt - (HEAP_AW + 1)'(1);
            if (i_cmd.post_chore) r_chore_cnt <= r_chore_cnt + (CHORE_AW + 1)'(1);
            if (i_cmd.chore_take) begin
                r_chore_cnt  <= r_chore_cnt - (CHORE_AW + 1)'(1);
                r_chore_head <= r_chore_head + CHORE_AW'(1);
            end
        end
    end

    // status to the controller
    assign o_stat.op          = r_op;
    assign o_stat.delay_zero  = (r_delay == '0);
    assign o_stat.chore_full  = (r_chore_cnt == (CHORE_AW + 1)'(CHORE_DEPTH));
    assign o_stat.chore_empty = (r_chore_cnt == '0);
    assign o_stat.heap_full   = (r_heap_cnt == (HEAP_AW + 1)'(HEAP_DEPTH));
    assign o_stat.heap_empty  = (r_heap_cnt == '0);
    assign o_stat.heap_one    = (r_heap_cnt == (HEAP_AW + 1)'(1));
    assign o_stat.k_zero      = (r_k == '0);
    assign o_stat.up_done     = !w_up_move;
    assign o_stat.dn_done     = !w_dn_move;

    assign o_result = r_out;

endmodule

/* src/timed_event_scheduler.sv */
// top level of the timed event scheduler: controller plus datapath
// depends on tes_pkg, tes_if, tes_ctrl and tes_dp
//
// One request at a time. A post of a chore, a full or empty answer, or an
// unknown operation passes the dispatch and finish states; a chore pop adds
// a read and a take; a heap insert adds a read and a compare per level
// climbed, and a place step when the new entry reaches the root; a heap pop
// adds a top read and a take and, unless it empties the heap, a read and a
// compare per level sifted down. The heap memory has one write and two
// registered reads, so each level reads before it compares. The result
// sits in an output register, so a new request is taken while the previous
// result still waits for its transfer. A write of start_time loads the
// current time at once and must come while no request is in flight.
module timed_event_scheduler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tes_pkg::TIME_BITS-1:0] i_cfg_wdata,
    tes_req_if.sink                       i_evt,
    tes_res_if.source                     o_res
);
    import tes_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_result  w_result;

    // sequencing
    tes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_evt.valid),
        .o_in_ready  (i_evt.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // stores and arithmetic
    tes_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_operation (i_evt.operation),
        .i_delay_ns  (i_evt.delay_ns),
        .i_tag       (i_evt.tag),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_result    (w_result)
    );

    // result payload
    assign o_res.status       = w_result.status;
    assign o_res.event_id     = w_result.event_id;
    assign o_res.event_tag    = w_result.event_tag;
    assign o_res.current_time = w_result.current_time;

endmodule

/* test/testbench.sv */
// self-checking testbench of the timed event scheduler
// depends on tes_pkg, tes_if and the timed_event_scheduler rtl
module testbench;
    import tes_pkg::*;

    typedef struct {
        logic [1:0]            op;
        logic [DELAY_BITS-1:0] delay;
        logic [TAG_BITS-1:0]   tag;
    } t_request;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 40;
    localparam int QUIET_FROM   = 500;
    localparam int QUIET_TO     = 2000;
    localparam int HOLD_AT      = 3000;
    localparam int HOLD_CYCLES  = 600;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [TIME_BITS-1:0] i_cfg_wdata;

    tes_req_if evt ();
    tes_res_if res ();

    timed_event_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_evt       (evt),
        .o_res       (res)
    );

    // scheduler shadow state
    logic [TIME_BITS-1:0] sched_now = '0;
    logic [ID_BITS-1:0]   sched_ids = '0;
    t_heap_ent            timed_store[$];
    t_chore_ent           chore_store[$];

    t_request pending_reqs[$];
    t_result  results_due[$];
    int       cycle = 0;
    int       mismatches = 0;
    int       hold_left = 0;

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit go_idle();
        if (cycle >= QUIET_FROM && cycle < QUIET_TO) return 1'b0;
        return $urandom_range(0, 99) < 23;
    endfunction

    function automatic logic [TIME_BITS-1:0] expiry_after(logic [DELAY_BITS-1:0] d);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, sched_now} + {{(TIME_BITS + 1 - DELAY_BITS){1'b0}}, d};
        return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
    endfunction

    // work out the result of one accepted request
    task automatic schedule_request(t_request rq);
        t_result   r;
        t_heap_ent e;
        int        best;
        r = '{status: ST_EMPTY, event_id: '0, event_tag: '0, current_time: '0};
        case (rq.op)
            OP_POST: begin
                if (rq.delay == 0) begin
                    if (chore_store.size() < CHORE_DEPTH) begin
                        sched_ids = sched_ids + ID_BITS'(2);
                        chore_store.push_back('{ident: sched_ids, handle: rq.tag});
                        r.status = ST_POSTED; r.event_id = sched_ids; r.event_tag = rq.tag;
                    end else r.status = ST_FULL;
                end else if (timed_store.size() < HEAP_DEPTH) begin
                    sched_ids = sched_ids + ID_BITS'(2);
                    e = '{expiry: expiry_after(rq.delay), ident: sched_ids + ID_BITS'(1),
                          stop: 1'b0, handle: rq.tag};
                    timed_store.push_back(e);
                    r.status = ST_POSTED; r.event_id = e.ident; r.event_tag = rq.tag;
                end else r.status = ST_FULL;
            end
            OP_STOP: begin
                if (timed_store.size() < HEAP_DEPTH) begin
                    timed_store.push_back('{expiry: expiry_after(rq.delay), ident: ID_STOP,
                                            stop: 1'b1, handle: '0});
                    r.status = ST_POSTED; r.event_id = ID_STOP;
                end else r.status = ST_FULL;
            end
            OP_POP: begin
                if (chore_store.size() > 0) begin
                    r.status = ST_CHORE;
                    r.event_id = chore_store[0].ident;
                    r.event_tag = chore_store[0].handle;
                    chore_store.delete(0);
                end else if (timed_store.size() > 0) begin
                    // smallest packed key comes out first
                    best = 0;
                    foreach (timed_store[i])
                        if (timed_store[i] < timed_store[best]) best = i;
                    e = timed_store[best];
                    timed_store.delete(best);
                    sched_now = e.expiry;
                    r.status = e.stop ? ST_STOP : ST_TIMED;
                    r.event_id = e.ident; r.event_tag = e.handle;
                end
            end
            default: ;
        endcase
        r.current_time = sched_now;
        results_due.push_back(r);
    endtask

    // request driver
    always @(posedge i_clk) begin : drive
        t_request nxt;
        if (!i_rst_n) begin
            evt.valid     <= 1'b0;
            evt.operation <= OP_POST;
            evt.delay_ns  <= '0;
            evt.tag       <= '0;
        end else begin
            if (evt.valid && evt.ready)
                schedule_request('{op: evt.operation, delay: evt.delay_ns, tag: evt.tag});
            if (!evt.valid || evt.ready) begin
                if (pending_reqs.size() > 0 && !go_idle()) begin
                    nxt = pending_reqs[0];
                    pending_reqs.delete(0);
                    evt.valid     <= 1'b1;
                    evt.operation <= nxt.op;
                    evt.delay_ns  <= nxt.delay;
                    evt.tag       <= nxt.tag;
                end else begin
                    evt.valid <= 1'b0;
                end
            end
        end
    end

    // result ready with one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (cycle == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            res.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end else begin
            res.ready <= !go_idle();
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch
        t_result want;
        if (i_rst_n && res.valid && res.ready) begin
            if (results_due.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result at cycle %0d: st %0d id %h tag %h t %h",
                             cycle, res.status, res.event_id, res.event_tag,
                             res.current_time);
            end else begin
                want = results_due[0];
                results_due.delete(0);
                if (res.status !== want.status || res.event_id !== want.event_id ||
                    res.event_tag !== want.event_tag ||
                    res.current_time !== want.current_time) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp st %0d id %h tag %h t %h, %s %0d %h %h %h",
                                 want.status, want.event_id, want.event_tag,
                                 want.current_time, "got st id tag t",
                                 res.status, res.event_id, res.event_tag,
                                 res.current_time);
                end
            end
        end
    end

    task automatic queue_req(logic [1:0] op, logic [DELAY_BITS-1:0] d, logic [TAG_BITS-1:0] t);
        pending_reqs.push_back('{op: op, delay: d, tag: t});
    endtask

    // mixed traffic: ties on small delays, some huge delays
    task automatic queue_random(int n);
        int   pick;
        logic [DELAY_BITS-1:0] d;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: d = '0;
                1: d = $urandom();
                default: d = DELAY_BITS'($urandom_range(1, 50));
            endcase
            if (pick < 50)      queue_req(OP_POST, d, TAG_BITS'($urandom()));
            else if (pick < 85) queue_req(OP_POP, $urandom(), TAG_BITS'($urandom()));
            else if (pick < 95) queue_req(OP_STOP, d, TAG_BITS'($urandom()));
            else                queue_req(OP_NONE, $urandom(), TAG_BITS'($urandom()));
        end
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_reqs.size() > 0 || evt.valid || results_due.size() > 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_start(logic [TIME_BITS-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sched_now = v;
    endtask

    task automatic pop_all(int n);
        repeat (n) queue_req(OP_POP, '0, '0);
    endtask

    // stimulus and end of run
    initial begin
        i_rst_n <= 1'b0; i_cfg_we <= 1'b0; i_cfg_wdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pop, chores, timed events, stop, ties, unknown op
        queue_req(OP_POP, '0, '0);
        queue_req(OP_POST, '0, 16'hFFFF);
        queue_req(OP_POST, '0, 16'h0000);
        queue_req(OP_POST, 32'hFFFF_FFFF, 16'hFFFF);
        queue_req(OP_POST, DELAY_BITS'(1), 16'h1234);
        queue_req(OP_POST, DELAY_BITS'(5), 16'h0002);
        queue_req(OP_POST, DELAY_BITS'(5), 16'h0001);
        queue_req(OP_STOP, DELAY_BITS'(5), 16'hBEEF);
        queue_req(OP_STOP, DELAY_BITS'(5), 16'h0000);
        queue_req(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF);
        pop_all(10);
        drain();

        // saturating expiry near the top of time
        write_start(TIME_MAX - TIME_BITS'(1000));
        queue_req(OP_POST, 32'hFFFF_FFFF, 16'hA5A5);
        queue_req(OP_STOP, 32'hFFFF_FFFF, 16'h0);
        queue_req(OP_POST, DELAY_BITS'(999), 16'h5A5A);
        pop_all(4);
        queue_random(40);
        drain();

        // chore fifo overflow
        write_start('0);
        repeat (CHORE_DEPTH + 2) queue_req(OP_POST, '0, TAG_BITS'($urandom()));
        pop_all(CHORE_DEPTH + 2);
        drain();

        // heap overflow, then part of it drained
        write_start(TIME_BITS'({$urandom(), $urandom()} >> 2));
        repeat (HEAP_DEPTH + 2) begin
            if ($urandom_range(0, 9) == 0)
                queue_req(OP_STOP, DELAY_BITS'($urandom_range(1, 40)), '0);
            else
                queue_req(OP_POST, DELAY_BITS'($urandom_range(1, 40)), TAG_BITS'($urandom()));
        end
        pop_all(60);
        drain();

        // random run at the top start time
        write_start(TIME_MAX);
        queue_random(40);
        drain();

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
